// ===== hdl/emft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emft_pkg
// Shared constants and types for the exact-match forwarding table.
// ----------------------------------------------------------------------------
package emft_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W      = 32;
  localparam int HOP_W       = 8;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 7;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [0:0] {
    REQ_LOOKUP = 1'b0,
    REQ_MAP    = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MATCHED  = 3'd0,
    ST_DEFAULT  = 3'd1,
    ST_NODEST   = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_INSERTED = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_HOP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_VALID = 1'b1;

endpackage
`default_nettype wire

// ===== hdl/emft_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emft_req_if
// Request channel: lookup or map transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface emft_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [emft_pkg::ADDR_W-1:0]   address;
  logic [emft_pkg::HOP_W-1:0]    next_hop;

  modport source (output valid, output req_type, output address, output next_hop,
                  input ready);
  modport sink   (input valid, input req_type, input address, input next_hop,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/emft_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emft_rsp_if
// Result channel: resolved hop, status and entry count with valid/ready.
// ----------------------------------------------------------------------------
interface emft_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [emft_pkg::HOP_W-1:0]        hop_out;
  logic [emft_pkg::STATUS_W-1:0]     status;
  logic [emft_pkg::COUNT_OUT_W-1:0]  count_out;

  modport source (output valid, output hop_out, output status, output count_out,
                  input ready);
  modport sink   (input valid, input hop_out, input status, input count_out,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/emft_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module emft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/exact_match_forwarding_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// exact_match_forwarding_table
// Linear-search forwarding table with default route; one transaction at a time.
// ----------------------------------------------------------------------------
// After accept, an empty table goes straight to the finish state; otherwise the
// prime and search states scan the entries until a hit or the last used one.
// The scan reads the address RAM one entry per cycle through a single compare.
// A new transaction is accepted the cycle after the result is registered.
// Reset (rst_n, synchronous, active low) clears the entry count, the default
// route registers and control state; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module exact_match_forwarding_table (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  emft_req_if.sink                                  in_ch,
  emft_rsp_if.source                                out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic [emft_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [emft_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRIME,
    S_SEARCH,
    S_FINISH
  } state_t;

  state_t                               state_r, state_nxt;
  logic [emft_pkg::CNT_W-1:0]           count_r, count_nxt;
  logic [emft_pkg::IDX_W-1:0]           rd_idx_r, rd_idx_nxt;
  logic [emft_pkg::IDX_W-1:0]           cmp_idx_r, cmp_idx_nxt;
  logic                                 found_r, found_nxt;
  logic [emft_pkg::IDX_W-1:0]           hit_idx_r, hit_idx_nxt;
  logic [emft_pkg::HOP_W-1:0]           hit_hop_r, hit_hop_nxt;
  logic                                 req_r, req_nxt;
  logic [emft_pkg::ADDR_W-1:0]          key_r, key_nxt;
  logic [emft_pkg::HOP_W-1:0]           hop_r, hop_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [emft_pkg::HOP_W-1:0]           out_hop_r, out_hop_nxt;
  emft_pkg::status_t                    out_status_r, out_status_nxt;
  logic [emft_pkg::COUNT_OUT_W-1:0]     out_count_r, out_count_nxt;
  logic [emft_pkg::HOP_W-1:0]           default_hop_r;
  logic                                 default_valid_r;

  logic                                 in_acc;
  logic                                 out_free;
  logic                                 hit;
  logic                                 cmp_last;
  logic                                 table_full;
  logic                                 finish_go;
  logic                                 addr_we;
  logic                                 hop_we;
  logic [emft_pkg::IDX_W-1:0]           waddr;
  logic [emft_pkg::ADDR_W-1:0]          addr_rdata;
  logic [emft_pkg::HOP_W-1:0]           hop_rdata;
  emft_pkg::status_t                    fin_status;
  logic [emft_pkg::HOP_W-1:0]           fin_hop;

  emft_ram #(
    .WIDTH (emft_pkg::ADDR_W),
    .DEPTH (emft_pkg::TABLE_DEPTH)
  ) u_addr_ram (
    .clk   (clk),
    .we    (addr_we),
    .waddr (waddr),
    .wdata (key_r),
    .raddr (rd_idx_r),
    .rdata (addr_rdata)
  );

  emft_ram #(
    .WIDTH (emft_pkg::HOP_W),
    .DEPTH (emft_pkg::TABLE_DEPTH)
  ) u_hop_ram (
    .clk   (clk),
    .we    (hop_we),
    .waddr (waddr),
    .wdata (hop_r),
    .raddr (rd_idx_r),
    .rdata (hop_rdata)
  );

  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_acc           = in_ch.valid && in_ch.ready;
  assign out_free         = !out_valid_r || out_ch.ready;
  assign hit              = (addr_rdata == key_r);
  assign cmp_last         = ((emft_pkg::CNT_W'(cmp_idx_r) + emft_pkg::CNT_W'(1)) == count_r);
  assign table_full       = (count_r == emft_pkg::CNT_W'(emft_pkg::TABLE_DEPTH));
  assign finish_go        = (state_r == S_FINISH) && out_free;
  assign waddr            = found_r ? hit_idx_r : emft_pkg::IDX_W'(count_r);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hop_out   = out_hop_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.count_out = out_count_r;

  // Result of the finished search, with the RAM writes and count update of a map
  always_comb begin
    fin_hop    = '0;
    fin_status = emft_pkg::ST_NODEST;
    addr_we    = 1'b0;
    hop_we     = 1'b0;
    count_nxt  = count_r;
    priority if (req_r == emft_pkg::REQ_LOOKUP) begin
      priority if (found_r) begin
        fin_hop    = hit_hop_r;
        fin_status = emft_pkg::ST_MATCHED;
      end else if (default_valid_r) begin
        fin_hop    = default_hop_r;
        fin_status = emft_pkg::ST_DEFAULT;
      end else begin
        fin_status = emft_pkg::ST_NODEST;
      end
    end else begin
      priority if (found_r) begin
        fin_status = emft_pkg::ST_UPDATED;
        hop_we     = finish_go;
      end else if (table_full) begin
        fin_status = emft_pkg::ST_FULL;
      end else begin
        fin_status = emft_pkg::ST_INSERTED;
        addr_we    = finish_go;
        hop_we     = finish_go;
        if (finish_go) begin
          count_nxt = count_r + emft_pkg::CNT_W'(1);
        end
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_hop_nxt    = hit_hop_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    hop_nxt        = hop_r;
    out_valid_nxt  = out_valid_r;
    out_hop_nxt    = out_hop_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt    = in_ch.req_type;
          key_nxt    = in_ch.address;
          hop_nxt    = in_ch.next_hop;
          found_nxt  = 1'b0;
          rd_idx_nxt = '0;
          state_nxt  = (count_r == '0) ? S_FINISH : S_PRIME;
        end
      end
      S_PRIME: begin
        cmp_idx_nxt = rd_idx_r;
        rd_idx_nxt  = rd_idx_r + emft_pkg::IDX_W'(1);
        state_nxt   = S_SEARCH;
      end
      S_SEARCH: begin
        if (hit) begin
          found_nxt   = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          hit_hop_nxt = hop_rdata;
          state_nxt   = S_FINISH;
        end else if (cmp_last) begin
          state_nxt   = S_FINISH;
        end else begin
          cmp_idx_nxt = rd_idx_r;
          rd_idx_nxt  = rd_idx_r + emft_pkg::IDX_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_hop_nxt    = fin_hop;
          out_status_nxt = fin_status;
          out_count_nxt  = emft_pkg::COUNT_OUT_W'(count_nxt);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    found_r      <= found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_hop_r    <= hit_hop_nxt;
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    hop_r        <= hop_nxt;
    out_hop_r    <= out_hop_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Default route registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_hop_r   <= '0;
      default_valid_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        emft_pkg::CFG_DEFAULT_HOP:   default_hop_r   <= cfg_wdata[emft_pkg::HOP_W-1:0];
        emft_pkg::CFG_DEFAULT_VALID: default_valid_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= emft_pkg::CNT_W'(emft_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ((count_r == emft_pkg::CNT_W'($past(count_r) + emft_pkg::CNT_W'(1))) &&
       (out_status_r == emft_pkg::ST_INSERTED)))
    else $error("entry count changed without an insert");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result registered outside finish state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (emft_pkg::CNT_W'(cmp_idx_r) < count_r))
    else $error("search index beyond used entries");

endmodule
`default_nettype wire
